// File: hw/rtl/sync_length_sum_frame_receiver_unit_defines.svh
// Assertion helpers for the frame receiver.
`ifndef SYNC_LENGTH_SUM_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_SUM_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SLSFR_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication, checked outside reset
`define SLSFR_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

// File: hw/rtl/slsfr_pkg.sv
package slsfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int SYNC_BYTES = 4;

    // Reset values of the configuration registers
    localparam logic [31:0]       SYNC_WORD_RST   = 32'h0000_0000;
    localparam logic [BYTE_W-1:0] MIN_LEN_RST     = 8'd4;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST     = 8'hFF;
    localparam logic [BYTE_W-1:0] TRAILER_LEN_RST = 8'd2;
    localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'd0;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_OK      = 3'd1,
        KIND_LEN_ERR = 3'd2,
        KIND_SUM_ERR = 3'd3,
        KIND_END_ERR = 3'd4
    } result_kind_t;

    typedef enum logic [2:0] {
        PH_SYNC0 = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_SYNC3 = 3'd3,
        PH_LEN   = 3'd4,
        PH_DATA  = 3'd5,
        PH_SUM   = 3'd6,
        PH_END   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        REG_SYNC_WORD   = 3'd0,
        REG_MIN_LEN     = 3'd1,
        REG_MAX_LEN     = 3'd2,
        REG_TRAILER_LEN = 3'd3,
        REG_END_BYTE    = 3'd4
    } reg_index_t;

endpackage

// File: hw/rtl/slsfr_if.sv
// Received byte channel
interface slsfr_in_if;
    import slsfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface slsfr_out_if;
    import slsfr_pkg::*;

    logic              valid;
    logic              ready;
    result_kind_t      result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] frame_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output frame_length, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_index, input frame_length, output ready);
endinterface

// File: hw/rtl/sync_length_sum_frame_receiver_unit.sv
// A result is registered on the output in the cycle after its byte transfer.
// Throughput: one byte per cycle; the frame state updates on each transfer and
// the output register lets a byte transfer in while the taken result leaves.
// The input stalls only while a result waits in the output register unread.
// Reset (rst_n, asynchronous, active low): first sync stage, counters and sum
// cleared, output empty, configuration registers at their reset values.
`include "sync_length_sum_frame_receiver_unit_defines.svh"

module sync_length_sum_frame_receiver_unit
    import slsfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    slsfr_in_if.sink              in_ch,
    slsfr_out_if.source           out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    logic [31:0]       sync_word_reg;
    logic [BYTE_W-1:0] min_len_reg;
    logic [BYTE_W-1:0] max_len_reg;
    logic [BYTE_W-1:0] trailer_len_reg;
    logic [BYTE_W-1:0] end_byte_reg;

    // Frame state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    result_kind_t      kind_reg;
    logic [BYTE_W-1:0] pbyte_reg;
    logic [BYTE_W-1:0] pindex_reg;
    logic [BYTE_W-1:0] flen_reg;

    // Result of the current byte
    logic              res_valid;
    result_kind_t      res_kind;
    logic [BYTE_W-1:0] res_byte;
    logic [BYTE_W-1:0] res_index;
    logic [BYTE_W-1:0] res_flen;

    logic              accept;
    logic              cfg_write;
    reg_index_t        cfg_sel;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] want;
    logic              len_bad;
    logic signed [BYTE_W+1:0] target;
    logic signed [BYTE_W+1:0] count_inc;

    assign b         = in_ch.rx_byte;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept    = in_ch.valid && in_ch.ready;
    assign cfg_sel   = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg   <= SYNC_WORD_RST;
            min_len_reg     <= MIN_LEN_RST;
            max_len_reg     <= MAX_LEN_RST;
            trailer_len_reg <= TRAILER_LEN_RST;
            end_byte_reg    <= END_BYTE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_SYNC_WORD:   sync_word_reg   <= pwdata;
                REG_MIN_LEN:     min_len_reg     <= pwdata[BYTE_W-1:0];
                REG_MAX_LEN:     max_len_reg     <= pwdata[BYTE_W-1:0];
                REG_TRAILER_LEN: trailer_len_reg <= pwdata[BYTE_W-1:0];
                REG_END_BYTE:    end_byte_reg    <= pwdata[BYTE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        case (cfg_sel)
            REG_SYNC_WORD:   prdata = sync_word_reg;
            REG_MIN_LEN:     prdata = {24'd0, min_len_reg};
            REG_MAX_LEN:     prdata = {24'd0, max_len_reg};
            REG_TRAILER_LEN: prdata = {24'd0, trailer_len_reg};
            REG_END_BYTE:    prdata = {24'd0, end_byte_reg};
            default:         prdata = '0;
        endcase
    end

    // Pick the expected sync byte for this stage
    always_comb
    begin
        case (phase_reg[1:0])
            2'd0:    want = sync_word_reg[7:0];
            2'd1:    want = sync_word_reg[15:8];
            2'd2:    want = sync_word_reg[23:16];
            default: want = sync_word_reg[31:24];
        endcase
    end

    assign len_bad   = (b < min_len_reg) || (b > max_len_reg);
    assign target    = $signed({2'b00, length_reg}) - $signed({2'b00, trailer_len_reg});
    assign count_inc = $signed({2'b00, count_reg}) + 10'sd1;

    // Advance the frame state and form the result of one byte
    always_comb
    begin
        phase_next = phase_reg;
        length_next = length_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        res_valid  = 1'b0;
        res_kind   = KIND_PAYLOAD;
        res_byte   = '0;
        res_index  = '0;
        res_flen   = length_reg;

        case (phase_reg)
            PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3:
            begin
                if (b == want)
                begin
                    phase_next = phase_t'(phase_reg + 3'd1);
                    if (phase_reg == PH_SYNC3)
                        count_next = '0;
                end
                else
                    phase_next = PH_SYNC0;
            end
            PH_LEN:
            begin
                length_next = b;
                res_flen    = b;
                if (len_bad)
                begin
                    phase_next = PH_SYNC0;
                    res_valid  = 1'b1;
                    res_kind   = KIND_LEN_ERR;
                end
                else
                begin
                    sum_next   = b;
                    count_next = '0;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                sum_next   = sum_reg + b;
                count_next = count_inc[BYTE_W-1:0];
                if (count_inc >= target)
                    phase_next = PH_SUM;
                res_valid = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_byte  = b;
                res_index = count_reg;
            end
            PH_SUM:
            begin
                if (sum_reg == b)
                    phase_next = PH_END;
                else
                begin
                    phase_next = PH_SYNC0;
                    res_valid  = 1'b1;
                    res_kind   = KIND_SUM_ERR;
                end
            end
            default:
            begin
                phase_next = PH_SYNC0;
                res_valid  = 1'b1;
                res_kind   = (b == end_byte_reg) ? KIND_OK : KIND_END_ERR;
            end
        endcase
    end

    // Drop the output once taken; load it on a transfer that yields a result
    always_comb
    begin
        if (accept)
            out_valid_next = res_valid;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC0;
            length_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                sum_reg    <= sum_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg   <= res_kind;
            pbyte_reg  <= res_byte;
            pindex_reg <= res_index;
            flen_reg   <= res_flen;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.result_kind   = kind_reg;
    assign out_ch.payload_byte  = pbyte_reg;
    assign out_ch.payload_index = pindex_reg;
    assign out_ch.frame_length  = flen_reg;

    // Checks
    `SLSFR_ASSERT_NOW(a_stall_blocks_input, out_valid_reg && !out_ch.ready, !in_ch.ready, "input taken while result pending")
    `SLSFR_ASSERT_NEXT(a_sync_no_result, accept && (phase_reg == PH_SYNC0 || phase_reg == PH_SYNC1 || phase_reg == PH_SYNC2 || phase_reg == PH_SYNC3), !out_valid_reg, "sync byte produced a result")
    `SLSFR_ASSERT_NEXT(a_data_gives_payload, accept && phase_reg == PH_DATA, out_valid_reg && kind_reg == KIND_PAYLOAD, "payload byte not reported")
    `SLSFR_ASSERT_NEXT(a_good_len_to_data, accept && phase_reg == PH_LEN && !len_bad, phase_reg == PH_DATA && !out_valid_reg, "valid length did not start payload")

endmodule

// File: dv/sync_length_sum_frame_receiver_unit_checker.sv
`timescale 1ns / 100ps

// Watches the byte and result channels and the register port, predicts the
// result of every byte transfer and compares each result transfer with it.
module slsfr_frame_checker
    import slsfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    slsfr_in_if                   in_ch,
    slsfr_out_if                  out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int unsigned           expected_left,
    output int unsigned           errors,
    output int unsigned           checked
);

    typedef struct {
        result_kind_t      kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] length;
    } frame_result_t;

    frame_result_t pending_results[$];

    // Shadow of the register file
    logic [31:0]       sync_word;
    logic [BYTE_W-1:0] min_len;
    logic [BYTE_W-1:0] max_len;
    logic [BYTE_W-1:0] trailer_len;
    logic [BYTE_W-1:0] end_byte;

    // Shadow of the frame state
    phase_t            phase;
    logic [BYTE_W-1:0] length_byte;
    logic [BYTE_W-1:0] byte_count;
    logic [BYTE_W-1:0] running_sum;

    int unsigned err_count;
    int unsigned results_checked;

    // Advance the frame state by one received byte
    function automatic void advance_frame(input logic [BYTE_W-1:0] rx, output bit produced,
                                          output frame_result_t res);
        int span;
        int next_count;
        produced = 1'b0;
        res = '{KIND_PAYLOAD, '0, '0, '0};
        case (phase)
            PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3:
            begin
                if (rx == sync_word[BYTE_W*int'(phase) +: BYTE_W])
                begin
                    phase = phase_t'(phase + 1);
                    if (phase == PH_LEN)
                        byte_count = '0;
                end
                else
                begin
                    // drop back; the failing byte is not tried as a first sync byte
                    phase = PH_SYNC0;
                end
            end
            PH_LEN:
            begin
                length_byte = rx;
                if (rx < min_len || rx > max_len)
                begin
                    phase = PH_SYNC0;
                    produced = 1'b1;
                    res.kind = KIND_LEN_ERR;
                end
                else
                begin
                    running_sum = rx;
                    byte_count = '0;
                    phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                // at least one payload byte, even when the trailer eats the length
                span = int'(length_byte) - int'(trailer_len);
                next_count = int'(byte_count) + 1;
                running_sum = running_sum + rx;
                produced = 1'b1;
                res.kind = KIND_PAYLOAD;
                res.value = rx;
                res.index = byte_count;
                byte_count = 8'(next_count);
                if (next_count >= span)
                    phase = PH_SUM;
            end
            PH_SUM:
            begin
                if (running_sum == rx)
                begin
                    phase = PH_END;
                end
                else
                begin
                    phase = PH_SYNC0;
                    produced = 1'b1;
                    res.kind = KIND_SUM_ERR;
                end
            end
            default:
            begin
                phase = PH_SYNC0;
                produced = 1'b1;
                res.kind = (rx == end_byte) ? KIND_OK : KIND_END_ERR;
            end
        endcase
        res.length = length_byte;
    endfunction

    task automatic flag_field(input string field, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
        $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field, want, got);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t predicted;
        frame_result_t oldest;
        bit produced;
        if (!rst_n)
        begin
            sync_word = SYNC_WORD_RST;
            min_len = MIN_LEN_RST;
            max_len = MAX_LEN_RST;
            trailer_len = TRAILER_LEN_RST;
            end_byte = END_BYTE_RST;
            phase = PH_SYNC0;
            length_byte = '0;
            byte_count = '0;
            running_sum = '0;
            pending_results.delete();
            err_count = 0;
            results_checked = 0;
            expected_left <= 0;
            errors <= 0;
            checked <= 0;
        end
        else
        begin
            // compare a result transfer with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d",
                             $time, out_ch.result_kind);
                    err_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (out_ch.result_kind !== oldest.kind)
                        flag_field("result_kind", 8'(oldest.kind), 8'(out_ch.result_kind));
                    if (out_ch.payload_byte !== oldest.value)
                        flag_field("payload_byte", oldest.value, out_ch.payload_byte);
                    if (out_ch.payload_index !== oldest.index)
                        flag_field("payload_index", oldest.index, out_ch.payload_index);
                    if (out_ch.frame_length !== oldest.length)
                        flag_field("frame_length", oldest.length, out_ch.frame_length);
                    results_checked++;
                end
            end

            // follow register writes; unknown indexes are ignored
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_SYNC_WORD:   sync_word = pwdata;
                    REG_MIN_LEN:     min_len = pwdata[BYTE_W-1:0];
                    REG_MAX_LEN:     max_len = pwdata[BYTE_W-1:0];
                    REG_TRAILER_LEN: trailer_len = pwdata[BYTE_W-1:0];
                    REG_END_BYTE:    end_byte = pwdata[BYTE_W-1:0];
                    default:         ;
                endcase
            end

            // predict the result of a byte transfer
            if (in_ch.valid && in_ch.ready)
            begin
                advance_frame(in_ch.rx_byte, produced, predicted);
                if (produced)
                    pending_results.push_back(predicted);
            end

            expected_left <= pending_results.size();
            errors <= err_count;
            checked <= results_checked;
        end
    end

endmodule

// File: dv/sync_length_sum_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps

module sync_length_sum_frame_receiver_unit_tb;
    import slsfr_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 7;
    localparam int PHASE_BUDGET   = 170;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned expected_left;
    int unsigned errors;
    int unsigned checked;

    slsfr_in_if  in_ch();
    slsfr_out_if out_ch();

    // Register values as last written, used to build frames
    logic [31:0]       cfg_sync    = SYNC_WORD_RST;
    logic [BYTE_W-1:0] cfg_min     = MIN_LEN_RST;
    logic [BYTE_W-1:0] cfg_max     = MAX_LEN_RST;
    logic [BYTE_W-1:0] cfg_trailer = TRAILER_LEN_RST;
    logic [BYTE_W-1:0] cfg_end     = END_BYTE_RST;

    bit          steady = 1'b0;
    int unsigned bytes_sent;
    int unsigned noise_sent;
    int unsigned frames_sent;
    int unsigned settings_applied;
    int unsigned quiet_cycles;

    sync_length_sum_frame_receiver_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    slsfr_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .expected_left (expected_left),
        .errors        (errors),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: stall a random number of cycles before each transfer
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Hold the byte channel idle until every result is out
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup and access phase; the bus drops only after the last write of a group
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value,
                             input bit closing);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (closing)
        begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
        case (index)
            REG_SYNC_WORD:   cfg_sync = value;
            REG_MIN_LEN:     cfg_min = value[BYTE_W-1:0];
            REG_MAX_LEN:     cfg_max = value[BYTE_W-1:0];
            REG_TRAILER_LEN: cfg_trailer = value[BYTE_W-1:0];
            REG_END_BYTE:    cfg_end = value[BYTE_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] sync, input logic [BYTE_W-1:0] lo,
                                input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] trl,
                                input logic [BYTE_W-1:0] eop);
        settle();
        write_reg(REG_SYNC_WORD, sync, 1'b0);
        write_reg(REG_MIN_LEN, 32'(lo), 1'b0);
        write_reg(REG_MAX_LEN, 32'(hi), 1'b0);
        write_reg(REG_TRAILER_LEN, 32'(trl), 1'b0);
        write_reg(REG_END_BYTE, 32'(eop), 1'b1);
        settings_applied++;
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] len);
        for (int i = 0; i < SYNC_BYTES; i++)
            send_byte(cfg_sync[BYTE_W*i +: BYTE_W]);
        send_byte(len);
    endtask

    // Full frame; fill below zero means random payload, else a constant byte
    task automatic send_frame(input logic [BYTE_W-1:0] len, input int fill,
                              input bit bad_sum, input bit bad_end);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] data;
        int count;
        count = (len > cfg_trailer) ? int'(len) - int'(cfg_trailer) : 1;
        send_header(len);
        sum = len;
        for (int i = 0; i < count; i++)
        begin
            data = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum += data;
            send_byte(data);
        end
        if (bad_sum)
        begin
            send_byte(sum ^ 8'($urandom_range(1, 255)));
        end
        else
        begin
            send_byte(sum);
            send_byte(bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
        end
        frames_sent++;
    endtask

    // Mostly good frames, bad lengths, noise, bad sync; only bad lengths if min>max
    task automatic random_traffic(input int budget);
        int unsigned start_bytes;
        int unsigned start_noise;
        int pick;
        int k;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] top_len;
        start_bytes = bytes_sent;
        start_noise = noise_sent;
        while ((bytes_sent - start_bytes) - (noise_sent - start_noise) < budget)
        begin
            steady = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (cfg_min > cfg_max)
            begin
                send_header(8'($urandom));
            end
            else if (pick < 12)
            begin
                if (cfg_max < 8'hFF && $urandom_range(0, 1) == 1)
                    len = 8'($urandom_range(int'(cfg_max) + 1, 255));
                else
                    len = 8'($urandom_range(0, int'(cfg_min) - 1));
                send_header(len);
            end
            else if (pick < 20)
            begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                    send_byte(8'($urandom));
                noise_sent += k;
            end
            else if (pick < 28)
            begin
                k = $urandom_range(1, SYNC_BYTES - 1);
                for (int i = 0; i < k; i++)
                    send_byte(cfg_sync[BYTE_W*i +: BYTE_W]);
                send_byte(cfg_sync[BYTE_W*k +: BYTE_W] ^ 8'($urandom_range(1, 255)));
                noise_sent += k + 1;
            end
            else
            begin
                // keep most frames short
                if ($urandom_range(0, 9) == 0)
                    top_len = cfg_max;
                else
                    top_len = (int'(cfg_max) < int'(cfg_min) + 8) ? cfg_max : cfg_min + 8'd8;
                len = 8'($urandom_range(int'(cfg_min), int'(top_len)));
                send_frame(len, -1, ($urandom_range(0, 9) == 0), ($urandom_range(0, 9) == 0));
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: sync mismatch without recheck, a good frame, short length
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'd4, -1, 1'b0, 1'b0);
        send_header(8'd3);

        // A write past the last register must change nothing
        settle();
        write_reg(3'(REG_END_BYTE + 1), 32'hFFFF_FFFF, 1'b1);

        apply_config(32'h1234_5678, 8'd2, 8'hFE, 8'd2, 8'h7E);
        send_header(8'hFF);
        send_frame(8'd2, 8'hFF, 1'b0, 1'b1);
        send_frame(8'd3, 8'h00, 1'b1, 1'b0);

        // Trailer rewritten in the middle of a frame shortens the payload
        send_header(8'd6);
        send_byte(8'h5A);
        settle();
        write_reg(REG_TRAILER_LEN, 32'd4, 1'b1);
        send_byte(8'hA5);
        send_byte(8'(8'd6 + 8'h5A + 8'hA5));
        send_byte(cfg_end);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_config(32'h0000_0000, 8'd1, 8'hFF, 8'd0, 8'hFF);
                1: apply_config(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'd254, 8'h00);
                2: apply_config($urandom, 8'd200, 8'd100, 8'd3, 8'($urandom));
                default:
                begin
                    logic [BYTE_W-1:0] lo;
                    lo = 8'($urandom_range(1, 32));
                    apply_config($urandom, lo, 8'($urandom_range(int'(lo), 255)),
                                 8'($urandom_range(0, int'(lo))), 8'($urandom));
                end
            endcase
            random_traffic(PHASE_BUDGET);
        end

        settle();
        $display("Sent %0d bytes (%0d frames, %0d noise) under %0d register settings.",
                 bytes_sent, frames_sent, noise_sent, settings_applied);
        $display("Compared %0d results; %0d still outstanding.", checked, expected_left);
        if (errors == 0 && expected_left == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
